FILE: src/fpa_pkg.sv
// Package for the fixed-point ALU: command codes, payload structs, per-cell stage type.
// Used by every module of the fixed_point_alu_unit block.
`default_nettype none
package fpa_pkg;
  localparam int unsigned FractionBits = 8;
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned NumWidth     = DataWidth + FractionBits;
  localparam int unsigned MagWidth     = 2 * DataWidth;

  typedef enum logic [3:0] {
    CmdAdd     = 4'd0,
    CmdSub     = 4'd1,
    CmdMul     = 4'd2,
    CmdDiv     = 4'd3,
    CmdCompare = 4'd4,
    CmdMin     = 4'd5,
    CmdMax     = 4'd6,
    CmdInc     = 4'd7,
    CmdDec     = 4'd8,
    CmdToInt   = 4'd9,
    CmdFromInt = 4'd10
  } cmd_e;

  typedef struct packed {
    logic [3:0]                  command;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_value;
    logic                        is_less;
    logic                        is_equal;
    logic                        is_greater;
    logic                        divide_by_zero;
    logic                        overflow;
  } out_item_t;

  // Division work carried from cell to cell; one quotient bit per cell.
  typedef struct packed {
    logic                  valid;
    logic                  is_div;
    logic                  neg;
    logic [NumWidth-1:0]   num;
    logic [DataWidth:0]    rem;
    logic [DataWidth-1:0]  den;
    logic [NumWidth-1:0]   quo;
    out_item_t             res;
  } stage_t;
endpackage
`default_nettype wire

FILE: src/fixed_point_alu_unit.sv
// Top level of the Q24.8 fixed-point ALU: entry stage, a row of division cells, exit stage.
// Depends on fpa_pkg, fpa_front, fpa_div_cell and fpa_back.
// A transfer is taken every cycle (busy_o is always low); each result appears with done_o
// high exactly one cycle, after passing one entry register (the multiply works on its
// outputs), one cell per quotient bit of the 40-bit dividend, then the output register.
// All commands travel the same row, so results come out in order; the receiver cannot stall.
`default_nettype none
module fixed_point_alu_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  fpa_pkg::in_item_t    item_i,
  output logic                 done_o,
  output fpa_pkg::out_item_t   result_o
);
  localparam int unsigned Cells = fpa_pkg::NumWidth;
  fpa_pkg::stage_t chain [Cells+1];

  assign busy_o = 1'b0;

  fpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .item_i  (item_i),
    .stage_o (chain[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  fpa_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (chain[Cells]),
    .done_o   (done_o),
    .result_o (result_o)
  );
endmodule
`default_nettype wire

FILE: src/fpa_div_cell.sv
// One restoring-division cell: shifts in a numerator bit, forms one quotient bit.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  fpa_pkg::stage_t     stage_i,
  output fpa_pkg::stage_t     stage_o
);
  fpa_pkg::stage_t stage_d, stage_q;
  logic            valid_q;
  logic [fpa_pkg::DataWidth+1:0] trial;
  logic [fpa_pkg::DataWidth:0]   shifted;

  always_comb begin
    stage_d = stage_i;
    shifted = {stage_i.rem[fpa_pkg::DataWidth-1:0], stage_i.num[fpa_pkg::NumWidth-1]};
    trial   = {1'b0, shifted} - {2'b00, stage_i.den};
    stage_d.num = {stage_i.num[fpa_pkg::NumWidth-2:0], 1'b0};
    if (!trial[fpa_pkg::DataWidth+1]) begin
      stage_d.rem = trial[fpa_pkg::DataWidth:0];
      stage_d.quo = {stage_i.quo[fpa_pkg::NumWidth-2:0], 1'b1};
    end else begin
      stage_d.rem = shifted;
      stage_d.quo = {stage_i.quo[fpa_pkg::NumWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end
endmodule
`default_nettype wire

FILE: src/fpa_front.sv
// Entry stage: simple ops, compare flags, registered multiply, division setup.
// Depends on fpa_pkg.
`default_nettype none
module fpa_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  fpa_pkg::in_item_t   item_i,
  output fpa_pkg::stage_t     stage_o
);
  localparam int unsigned W = fpa_pkg::DataWidth;
  localparam int unsigned F = fpa_pkg::FractionBits;

  // stage 1 registers
  logic            v1_q;
  fpa_pkg::stage_t s1_q;
  logic            is_mul_q;
  logic [W-1:0]    ma_q, mb_q;

  logic [W-1:0] ma, mb, ua, ub;
  logic         neg, is_div, dbz;
  fpa_pkg::out_item_t r;

  always_comb begin
    ua  = item_i.operand_a;
    ub  = item_i.operand_b;
    ma  = item_i.operand_a[W-1] ? (~ua + 1'b1) : ua;
    mb  = item_i.operand_b[W-1] ? (~ub + 1'b1) : ub;
    neg = item_i.operand_a[W-1] ^ item_i.operand_b[W-1];
    r   = '0;
    r.is_less    = item_i.operand_a <  item_i.operand_b;
    r.is_equal   = item_i.operand_a == item_i.operand_b;
    r.is_greater = item_i.operand_a >  item_i.operand_b;
    is_div = 1'b0;
    dbz    = 1'b0;
    unique case (item_i.command)
      fpa_pkg::CmdAdd:     r.result_value = ua + ub;
      fpa_pkg::CmdSub:     r.result_value = ua - ub;
      fpa_pkg::CmdMin:     r.result_value = r.is_less ? ua : ub;
      fpa_pkg::CmdMax:     r.result_value = r.is_greater ? ua : ub;
      fpa_pkg::CmdInc:     r.result_value = ua + 1'b1;
      fpa_pkg::CmdDec:     r.result_value = ua - 1'b1;
      fpa_pkg::CmdToInt:   r.result_value = item_i.operand_a >>> F;
      fpa_pkg::CmdFromInt: r.result_value = ua << F;
      fpa_pkg::CmdDiv: begin
        if (ub == '0) begin
          dbz = 1'b1;
        end else begin
          is_div = 1'b1;
        end
      end
      default:             r.result_value = '0;
    endcase
    r.divide_by_zero = dbz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q.valid  <= 1'b0;
    s1_q.is_div <= is_div;
    s1_q.neg    <= neg;
    s1_q.num    <= {ma, {F{1'b0}}};
    s1_q.rem    <= '0;
    s1_q.den    <= mb;
    s1_q.quo    <= '0;
    s1_q.res    <= r;
    is_mul_q    <= item_i.command == fpa_pkg::CmdMul;
    ma_q        <= ma;
    mb_q        <= mb;
  end

  // multiply result folded in after the operand register
  logic [fpa_pkg::MagWidth-1:0] prod;
  logic [fpa_pkg::MagWidth-1:0] qm;
  always_comb begin
    prod = ma_q * mb_q;
    qm   = (prod + (fpa_pkg::MagWidth'(1) << (F - 1))) >> F;
    stage_o       = s1_q;
    stage_o.valid = v1_q;
    if (is_mul_q) begin
      if (s1_q.neg) begin
        if (qm > fpa_pkg::MagWidth'(64'h8000_0000)) begin
          stage_o.res.result_value = {1'b1, {(W-1){1'b0}}};
          stage_o.res.overflow     = 1'b1;
        end else begin
          stage_o.res.result_value = ~qm[W-1:0] + 1'b1;
        end
      end else if (qm > fpa_pkg::MagWidth'(64'h7FFF_FFFF)) begin
        stage_o.res.result_value = {1'b0, {(W-1){1'b1}}};
        stage_o.res.overflow     = 1'b1;
      end else begin
        stage_o.res.result_value = qm[W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/fpa_back.sv
// Exit stage: rounds and saturates the quotient, registers the result strobe.
// Depends on fpa_pkg.
`default_nettype none
module fpa_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  fpa_pkg::stage_t      stage_i,
  output logic                 done_o,
  output fpa_pkg::out_item_t   result_o
);
  localparam int unsigned W = fpa_pkg::DataWidth;
  logic [fpa_pkg::NumWidth:0] q;
  logic                       rnd;
  fpa_pkg::out_item_t         r;

  always_comb begin
    r   = stage_i.res;
    rnd = {stage_i.rem, 1'b0} >= {2'b00, stage_i.den};
    q   = {1'b0, stage_i.quo} + {{fpa_pkg::NumWidth{1'b0}}, rnd};
    if (stage_i.is_div) begin
      if (stage_i.neg) begin
        if (q > (fpa_pkg::NumWidth+1)'(64'h8000_0000)) begin
          r.result_value = {1'b1, {(W-1){1'b0}}};
          r.overflow     = 1'b1;
        end else begin
          r.result_value = ~q[W-1:0] + 1'b1;
        end
      end else if (q > (fpa_pkg::NumWidth+1)'(64'h7FFF_FFFF)) begin
        r.result_value = {1'b0, {(W-1){1'b1}}};
        r.overflow     = 1'b1;
      end else begin
        r.result_value = q[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o <= r;
  end
endmodule
`default_nettype wire
